@@ src/cfhd_pkg.sv @@
// Shared types and constants for the camera frame header deframer.
// Holds header layout, result codes and register indexes; no dependencies.

package cfhd_pkg;

    // header layout, byte positions within the 24-byte header
    localparam int          HDR_INDEX_BITS = 5;
    localparam logic [4:0]  IDX_MAGIC_END  = 5'd3;
    localparam logic [4:0]  IDX_VERSION    = 5'd4;
    localparam logic [4:0]  IDX_DEVICE     = 5'd5;
    localparam logic [4:0]  IDX_EVENT_BEG  = 5'd8;
    localparam logic [4:0]  IDX_EVENT_END  = 5'd15;
    localparam logic [4:0]  IDX_SIZE_BEG   = 5'd16;
    localparam logic [4:0]  IDX_SIZE_END   = 5'd19;
    localparam logic [4:0]  IDX_HDR_LAST   = 5'd23;

    // result kinds
    localparam logic [1:0]  KIND_HDR_OK    = 2'd0;
    localparam logic [1:0]  KIND_HDR_BAD   = 2'd1;
    localparam logic [1:0]  KIND_PAYLOAD   = 2'd2;

    // error codes
    localparam logic [2:0]  ERR_NONE       = 3'd0;
    localparam logic [2:0]  ERR_MAGIC      = 3'd1;
    localparam logic [2:0]  ERR_VERSION    = 3'd2;
    localparam logic [2:0]  ERR_DEVICE     = 3'd3;
    localparam logic [2:0]  ERR_SIZE       = 3'd4;

    // configuration register indexes
    localparam int          CFG_INDEX_BITS = 2;
    localparam logic [1:0]  CFG_MAGIC      = 2'd0;
    localparam logic [1:0]  CFG_VERSION    = 2'd1;
    localparam logic [1:0]  CFG_DEV_COUNT  = 2'd2;
    localparam logic [1:0]  CFG_MAX_BYTES  = 2'd3;

    // register reset values
    localparam logic [31:0] RST_MAGIC      = 32'hCAFEBABE;
    localparam logic [7:0]  RST_VERSION    = 8'd2;
    localparam logic [7:0]  RST_DEV_COUNT  = 8'd4;
    localparam logic [23:0] RST_MAX_BYTES  = 24'd500000;

    localparam int          OUT_DATA_BITS  = 120;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [7:0]  source_dev;
        logic [63:0] corr_key;
        logic [31:0] payload_size;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

@@ src/camera_frame_header_deframer.sv @@
// Camera frame header deframer: splits a connection byte stream into
// header results and flagged payload bytes.
// Depends on cfhd_pkg for layout, codes and the result type.
//
// Usage:
//   s_axis carries one stream byte per request: tdata[7:0] is the byte,
//   tuser[0] marks the first byte of a new connection.
//   m_axis carries one result per request: tuser[1:0] is the kind, tlast
//   flags the last payload byte, tdata holds the header fields and byte.
//   The config channel writes one register per request (index, data); it is
//   always ready and is meant to be written while the stream is idle.
// Timing:
//   one byte is taken every cycle while s_axis tready is high; results are
//   registered. All work for a byte sits between the input handshake and
//   the output register, so throughput is one byte per cycle while s_axis
//   tready is high. Header byte 24 runs the field checks (32-bit compares).
// Reset and stall:
//   reset returns to header collection with the registers at their defaults.
//   When m_axis stalls, one more result is held in a skid register; s_axis
//   tready drops only while that skid register is full.

module camera_frame_header_deframer #(
    parameter int PAYLOAD_COUNT_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] new_connection
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [cfhd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // [2:0] error_code, [10:3] source_dev, [74:11] corr_key,
    // [106:75] payload_size, [114:107] payload_byte, [119:115] zero
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast,   // last
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [cfhd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    localparam logic [PAYLOAD_COUNT_BITS-1:0] LEFT_ONE = PAYLOAD_COUNT_BITS'(1);

    // configuration registers
    logic [31:0] r_exp_magic;
    logic [7:0]  r_exp_version;
    logic [7:0]  r_dev_count;
    logic [23:0] r_max_bytes;

    // frame state
    t_phase                  r_phase,   n_phase;
    logic [4:0]              r_index,   n_index;
    logic [31:0]             r_magic,   n_magic;
    logic [7:0]              r_version, n_version;
    logic [7:0]              r_device,  n_device;
    logic [63:0]             r_event,   n_event;
    logic [31:0]             r_size,    n_size;
    logic [PAYLOAD_COUNT_BITS-1:0] r_left, n_left;

    // output register and skid
    logic                 r_out_valid;
    cfhd_pkg::t_result    r_out;
    logic                 r_skid_valid;
    cfhd_pkg::t_result    r_skid;

    logic                 in_acc;
    logic                 out_pop;
    logic                 res_valid;
    cfhd_pkg::t_result    res;
    logic [2:0]           err;
    logic [63:0]          size_ext;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign o_cfg_ready   = 1'b1;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= cfhd_pkg::RST_MAGIC;
            r_exp_version <= cfhd_pkg::RST_VERSION;
            r_dev_count   <= cfhd_pkg::RST_DEV_COUNT;
            r_max_bytes   <= cfhd_pkg::RST_MAX_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cfhd_pkg::CFG_MAGIC:     r_exp_magic   <= i_cfg_data;
                cfhd_pkg::CFG_VERSION:   r_exp_version <= i_cfg_data[7:0];
                cfhd_pkg::CFG_DEV_COUNT: r_dev_count   <= i_cfg_data[7:0];
                cfhd_pkg::CFG_MAX_BYTES: r_max_bytes   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // per-byte next state and result
    always_comb begin
        n_phase   = r_phase;
        n_index   = r_index;
        n_magic   = r_magic;
        n_version = r_version;
        n_device  = r_device;
        n_event   = r_event;
        n_size    = r_size;
        n_left    = r_left;
        res_valid = 1'b0;
        err       = cfhd_pkg::ERR_NONE;
        size_ext  = 64'd0;

        // a new connection restarts header collection on this byte
        if (s_axis_tuser[0]) begin
            n_phase   = PH_HEADER;
            n_index   = 5'd0;
            n_magic   = 32'd0;
            n_version = 8'd0;
            n_device  = 8'd0;
            n_event   = 64'd0;
            n_size    = 32'd0;
            n_left    = '0;
        end

        unique case (n_phase)
            PH_HEADER: begin
                // shift the byte into its field
                if (n_index <= cfhd_pkg::IDX_MAGIC_END) begin
                    n_magic = {n_magic[23:0], s_axis_tdata};
                end else if (n_index == cfhd_pkg::IDX_VERSION) begin
                    n_version = s_axis_tdata;
                end else if (n_index == cfhd_pkg::IDX_DEVICE) begin
                    n_device = s_axis_tdata;
                end else if (n_index >= cfhd_pkg::IDX_EVENT_BEG &&
                             n_index <= cfhd_pkg::IDX_EVENT_END) begin
                    n_event = {n_event[55:0], s_axis_tdata};
                end else if (n_index >= cfhd_pkg::IDX_SIZE_BEG &&
                             n_index <= cfhd_pkg::IDX_SIZE_END) begin
                    n_size = {n_size[23:0], s_axis_tdata};
                end

                if (n_index != cfhd_pkg::IDX_HDR_LAST) begin
                    n_index = n_index + 5'd1;
                end else begin
                    // header complete: check fields in order
                    n_index  = 5'd0;
                    size_ext = {32'd0, n_size};
                    if (n_magic != r_exp_magic)
                        err = cfhd_pkg::ERR_MAGIC;
                    else if (n_version != r_exp_version)
                        err = cfhd_pkg::ERR_VERSION;
                    else if (n_device >= r_dev_count)
                        err = cfhd_pkg::ERR_DEVICE;
                    else if (n_size == 32'd0 || n_size > {8'd0, r_max_bytes} ||
                             (size_ext >> PAYLOAD_COUNT_BITS) != 64'd0)
                        err = cfhd_pkg::ERR_SIZE;
                    res_valid = 1'b1;
                    if (err != cfhd_pkg::ERR_NONE) begin
                        n_phase = PH_DROP;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        n_left  = n_size[PAYLOAD_COUNT_BITS-1:0];
                    end
                end
            end
            PH_PAYLOAD: begin
                res_valid = 1'b1;
                if (n_left <= LEFT_ONE) begin
                    n_phase = PH_HEADER;
                    n_index = 5'd0;
                    n_left  = '0;
                end else begin
                    n_left = n_left - LEFT_ONE;
                end
            end
            default: ;
        endcase

        // result fields
        res.source_dev   = n_device;
        res.corr_key     = n_event;
        res.payload_size = n_size;
        res.error_code   = err;
        if (r_phase == PH_PAYLOAD && !s_axis_tuser[0]) begin
            res.kind         = cfhd_pkg::KIND_PAYLOAD;
            res.payload_byte = s_axis_tdata;
            res.last         = (r_left <= LEFT_ONE);
        end else begin
            res.kind         = (err != cfhd_pkg::ERR_NONE) ? cfhd_pkg::KIND_HDR_BAD
                                                           : cfhd_pkg::KIND_HDR_OK;
            res.payload_byte = 8'd0;
            res.last         = 1'b0;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_index   <= 5'd0;
            r_magic   <= 32'd0;
            r_version <= 8'd0;
            r_device  <= 8'd0;
            r_event   <= 64'd0;
            r_size    <= 32'd0;
            r_left    <= '0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_index   <= n_index;
            r_magic   <= n_magic;
            r_version <= n_version;
            r_device  <= n_device;
            r_event   <= n_event;
            r_size    <= n_size;
            r_left    <= n_left;
        end
    end

    // output register with one-deep skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_acc && res_valid) begin
                if (!r_out_valid || out_pop) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {5'd0, r_out.payload_byte, r_out.payload_size,
                            r_out.corr_key, r_out.source_dev, r_out.error_code};

    // skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // a payload in progress always has bytes left
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with zero bytes left");

    // dropping holds until a new connection
    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_DROP && !s_axis_tuser[0]) |=> (r_phase == PH_DROP))
        else $error("left drop phase without a new connection");

    // header index stays within the header
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= cfhd_pkg::IDX_HDR_LAST)
        else $error("header index beyond header length");

endmodule

@@ tb/tb_camera_frame_header_deframer.sv @@
// Testbench for camera_frame_header_deframer: drives framed byte streams under
// several register settings and checks every result against a built-in predictor.
// Depends on cfhd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_camera_frame_header_deframer;

    localparam int           COUNT_BITS  = 24;
    localparam longint       COUNT_MAX   = (64'd1 << COUNT_BITS) - 1;
    localparam int           DRAIN_LIMIT = 20000;

    typedef enum logic [1:0] {PH_COLLECT, PH_PAYLOAD, PH_DROP} t_phase;

    // expected results of the deframer, worked out byte by byte
    class cfhd_scoreboard;
        logic [31:0]           magic_reg;
        logic [7:0]            version_reg;
        logic [7:0]            dev_count_reg;
        logic [23:0]           max_bytes_reg;

        t_phase                phase;
        logic [4:0]            hdr_idx;
        logic [31:0]           magic_acc;
        logic [7:0]            version_acc;
        logic [7:0]            device_acc;
        logic [63:0]           event_acc;
        logic [31:0]           size_acc;
        logic [COUNT_BITS-1:0] bytes_left;

        cfhd_pkg::t_result     pending_results[$];
        int                    errors;
        int                    live_bytes;

        function new();
            magic_reg     = cfhd_pkg::RST_MAGIC;
            version_reg   = cfhd_pkg::RST_VERSION;
            dev_count_reg = cfhd_pkg::RST_DEV_COUNT;
            max_bytes_reg = cfhd_pkg::RST_MAX_BYTES;
            restart_header();
            errors        = 0;
            live_bytes    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                cfhd_pkg::CFG_MAGIC:     magic_reg     = data;
                cfhd_pkg::CFG_VERSION:   version_reg   = data[7:0];
                cfhd_pkg::CFG_DEV_COUNT: dev_count_reg = data[7:0];
                cfhd_pkg::CFG_MAX_BYTES: max_bytes_reg = data[23:0];
                default: ;
            endcase
        endfunction

        function void restart_header();
            phase       = PH_COLLECT;
            hdr_idx     = '0;
            magic_acc   = '0;
            version_acc = '0;
            device_acc  = '0;
            event_acc   = '0;
            size_acc    = '0;
            bytes_left  = '0;
        endfunction

        function cfhd_pkg::t_result make_result(logic [1:0] kind, logic [2:0] err,
                                                logic [7:0] pbyte, logic last);
            cfhd_pkg::t_result r;
            r.kind         = kind;
            r.error_code   = err;
            r.source_dev   = device_acc;
            r.corr_key     = event_acc;
            r.payload_size = size_acc;
            r.payload_byte = pbyte;
            r.last         = last;
            return r;
        endfunction

        // note one accepted stream byte and queue the result it causes
        function void note_byte(logic [7:0] b, logic nc);
            logic [2:0] err;
            if (nc)
                restart_header();
            if (phase != PH_COLLECT && phase != PH_PAYLOAD)
                return;
            live_bytes++;
            if (phase == PH_COLLECT) begin
                // shift the header fields in, big-endian
                if (hdr_idx <= cfhd_pkg::IDX_MAGIC_END)
                    magic_acc = {magic_acc[23:0], b};
                else if (hdr_idx == cfhd_pkg::IDX_VERSION)
                    version_acc = b;
                else if (hdr_idx == cfhd_pkg::IDX_DEVICE)
                    device_acc = b;
                else if (hdr_idx >= cfhd_pkg::IDX_EVENT_BEG &&
                         hdr_idx <= cfhd_pkg::IDX_EVENT_END)
                    event_acc = {event_acc[55:0], b};
                else if (hdr_idx >= cfhd_pkg::IDX_SIZE_BEG &&
                         hdr_idx <= cfhd_pkg::IDX_SIZE_END)
                    size_acc = {size_acc[23:0], b};

                if (hdr_idx != cfhd_pkg::IDX_HDR_LAST) begin
                    hdr_idx = hdr_idx + 5'd1;
                    return;
                end
                hdr_idx = '0;

                // field checks in priority order
                if (magic_acc != magic_reg)
                    err = cfhd_pkg::ERR_MAGIC;
                else if (version_acc != version_reg)
                    err = cfhd_pkg::ERR_VERSION;
                else if (device_acc >= dev_count_reg)
                    err = cfhd_pkg::ERR_DEVICE;
                else if (size_acc == 32'd0 || size_acc > {8'd0, max_bytes_reg} ||
                         {32'd0, size_acc} > COUNT_MAX)
                    err = cfhd_pkg::ERR_SIZE;
                else
                    err = cfhd_pkg::ERR_NONE;

                if (err != cfhd_pkg::ERR_NONE) begin
                    phase = PH_DROP;
                    pending_results.push_back(make_result(cfhd_pkg::KIND_HDR_BAD, err,
                                                          8'd0, 1'b0));
                end else begin
                    phase      = PH_PAYLOAD;
                    bytes_left = size_acc[COUNT_BITS-1:0];
                    pending_results.push_back(make_result(cfhd_pkg::KIND_HDR_OK,
                                                          cfhd_pkg::ERR_NONE, 8'd0, 1'b0));
                end
            end else begin
                // payload pass-through, last byte flagged
                if (bytes_left <= 1) begin
                    pending_results.push_back(make_result(cfhd_pkg::KIND_PAYLOAD,
                                                          cfhd_pkg::ERR_NONE, b, 1'b1));
                    phase      = PH_COLLECT;
                    hdr_idx    = '0;
                    bytes_left = '0;
                end else begin
                    pending_results.push_back(make_result(cfhd_pkg::KIND_PAYLOAD,
                                                          cfhd_pkg::ERR_NONE, b, 1'b0));
                    bytes_left = bytes_left - 1'b1;
                end
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(cfhd_pkg::t_result got);
            cfhd_pkg::t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual kind %0d err %0d byte %h",
                         $time, got.kind, got.error_code, got.payload_byte);
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
            compare_field("source_dev", 64'(want.source_dev), 64'(got.source_dev));
            compare_field("corr_key", want.corr_key, got.corr_key);
            compare_field("payload_size", 64'(want.payload_size), 64'(got.payload_size));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction

        function void flush_leftovers();
            cfhd_pkg::t_result want;
            while (pending_results.size() != 0) begin
                want = pending_results.pop_front();
                errors++;
                $display("%0t: missing result, expected kind %0d err %0d byte %h, actual none",
                         $time, want.kind, want.error_code, want.payload_byte);
            end
        endfunction
    endclass

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata  = '0;
    logic [0:0]    s_axis_tuser  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [cfhd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;
    logic          i_cfg_valid   = 1'b0;
    logic          o_cfg_ready;
    logic [cfhd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [31:0]   i_cfg_data    = '0;

    cfhd_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    logic          hold_req      = 1'b0;
    logic          hold_ready    = 1'b0;
    logic          need_restart  = 1'b0;

    camera_frame_header_deframer #(
        .PAYLOAD_COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // safety net against a hung run
    initial begin
        #10_000_000;
        $display("[camera_frame_header_deframer] ERROR");
        $finish;
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_req);
        hold_ready <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_ready <= 1'b0;
    end

    // result side: check each accepted result, then pick the next ready
    always @(posedge i_clk) begin
        cfhd_pkg::t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind         = m_axis_tuser;
            got.error_code   = m_axis_tdata[2:0];
            got.source_dev   = m_axis_tdata[10:3];
            got.corr_key     = m_axis_tdata[74:11];
            got.payload_size = m_axis_tdata[106:75];
            got.payload_byte = m_axis_tdata[114:107];
            got.last         = m_axis_tlast;
            sb.check_result(got);
        end
        m_axis_tready <= !hold_ready && ($urandom_range(99) >= recv_idle_pct);
    end

    // one stream byte per request, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic nc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= nc;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, nc);
    endtask

    // first nbytes of a 24-byte big-endian header
    task automatic send_header(input logic nc, input logic [31:0] magic, input logic [7:0] ver,
                               input logic [7:0] dev, input logic [63:0] evid,
                               input logic [31:0] size, input int nbytes);
        logic [191:0] hdr;
        hdr = {magic, ver, dev, 16'($urandom), evid, size, 32'($urandom)};
        for (int i = 0; i < nbytes; i++)
            send_byte(hdr[191 - 8*i -: 8], (i == 0) ? nc : 1'b0);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    // stop offering and wait until every expected result has come
    task automatic settle_stream();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        settle_stream();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // one frame drawn at random: mostly well formed, some broken or noise
    task automatic random_frame();
        logic        nc;
        logic [31:0] mg;
        logic [7:0]  vr;
        logic [7:0]  dv;
        logic [63:0] evid;
        logic [31:0] size;
        int          lim;
        int          pick;
        int          n;
        nc   = need_restart || ($urandom_range(3) == 0);
        mg   = sb.magic_reg;
        vr   = sb.version_reg;
        dv   = 8'($urandom_range(int'(sb.dev_count_reg) - 1, 0));
        evid = {$urandom, $urandom};
        lim  = ($urandom_range(19) == 0) ? 200 : 16;
        if (int'(sb.max_bytes_reg) < lim)
            lim = int'(sb.max_bytes_reg);
        size = $urandom_range(lim, 1);
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_header(nc, mg, vr, dv, evid, size, 24);
            if ($urandom_range(9) == 0) begin
                // cut short, the next frame must open a new connection
                send_payload($urandom_range(size - 1, 0));
                need_restart = 1'b1;
            end else begin
                send_payload(size);
                need_restart = 1'b0;
            end
        end else if (pick < 85) begin
            case ($urandom_range(3))
                0: mg = mg ^ (32'd1 << $urandom_range(31));
                1: vr = vr ^ 8'($urandom_range(255, 1));
                2: dv = 8'($urandom_range(255, int'(sb.dev_count_reg)));
                default: size = ($urandom_range(1) == 0) ? 32'd0 :
                                {8'd0, sb.max_bytes_reg} + 32'd1 +
                                (($urandom_range(2) == 0) ? ($urandom >> 1) : $urandom_range(50));
            endcase
            send_header(nc, mg, vr, dv, evid, size, 24);
            send_payload($urandom_range(4));
            need_restart = 1'b1;
        end else if (pick < 93) begin
            send_header(nc, mg, vr, dv, evid, size, $urandom_range(23, 1));
            need_restart = 1'b1;
        end else begin
            n = $urandom_range(8, 1);
            repeat (n) send_byte(8'($urandom), $urandom_range(7) == 0);
            need_restart = 1'b1;
        end
    endtask

    task automatic run_random(input int budget);
        int start;
        start = sb.live_bytes;
        while (sb.live_bytes - start < budget)
            random_frame();
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed frames at reset settings
        send_idle_pct = 18;
        recv_idle_pct = 58;
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd0, 64'd0, 32'd1, 24);
        send_byte(8'h00, 1'b0);
        send_header(1'b0, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd3, '1, 32'd2, 24);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        // new connection abandons a payload, then a header
        send_header(1'b0, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd1,
                    64'h0123456789ABCDEF, 32'd5, 24);
        send_payload(2);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd2,
                    {$urandom, $urandom}, 32'd3, 10);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd2,
                    {$urandom, $urandom}, 32'd3, 24);
        send_payload(3);
        // each rejection, some with dropped bytes behind it
        send_header(1'b0, cfhd_pkg::RST_MAGIC ^ 32'd1, cfhd_pkg::RST_VERSION, 8'd0, '1,
                    32'd4, 24);
        send_payload(3);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION + 8'd1, 8'd0, '1,
                    32'd4, 24);
        send_payload(2);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, cfhd_pkg::RST_DEV_COUNT,
                    '1, 32'd4, 24);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd0, '1, 32'd0, 24);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd0, '1,
                    {8'd0, cfhd_pkg::RST_MAX_BYTES} + 32'd1, 24);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'hFF, '1,
                    32'hFFFF_FFFF, 24);
        // several bad fields at once: the first check wins
        send_header(1'b1, ~cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd200, '0, 32'd0, 24);
        send_header(1'b1, cfhd_pkg::RST_MAGIC, 8'd0, 8'd0, '0, 32'd0, 24);
        // receiver holds off while a long frame is offered
        hold_req = 1'b1;
        send_header(1'b1, cfhd_pkg::RST_MAGIC, cfhd_pkg::RST_VERSION, 8'd1,
                    {$urandom, $urandom}, 32'd60, 24);
        send_payload(60);
        need_restart = 1'b0;
        run_random(160);

        // widest settings
        write_reg(cfhd_pkg::CFG_MAGIC, 32'h0000_0000);
        write_reg(cfhd_pkg::CFG_VERSION, 32'h0000_0000);
        write_reg(cfhd_pkg::CFG_DEV_COUNT, 32'd255);
        write_reg(cfhd_pkg::CFG_MAX_BYTES, 32'h00FF_FFFF);
        send_header(1'b1, 32'd0, 8'd0, 8'd254, {$urandom, $urandom}, 32'h00FF_FFFF, 24);
        send_payload(3);
        send_header(1'b1, 32'd0, 8'd0, 8'd255, '1, 32'd1, 24);
        send_header(1'b1, 32'd0, 8'd0, 8'd0, '1, 32'h0100_0000, 24);
        need_restart = 1'b1;
        run_random(160);

        // narrowest settings
        send_idle_pct = 58;
        recv_idle_pct = 18;
        write_reg(cfhd_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(cfhd_pkg::CFG_VERSION, 32'h0000_00FF);
        write_reg(cfhd_pkg::CFG_DEV_COUNT, 32'd1);
        write_reg(cfhd_pkg::CFG_MAX_BYTES, 32'd1);
        send_header(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'd0, {$urandom, $urandom}, 32'd1, 24);
        send_payload(1);
        send_header(1'b0, 32'hFFFF_FFFF, 8'hFF, 8'd0, {$urandom, $urandom}, 32'd2, 24);
        need_restart = 1'b1;
        run_random(190);

        // zero device count and zero size limit reject everything
        write_reg(cfhd_pkg::CFG_DEV_COUNT, 32'd0);
        write_reg(cfhd_pkg::CFG_MAX_BYTES, 32'd0);
        send_header(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'd0, {$urandom, $urandom}, 32'd1, 24);
        write_reg(cfhd_pkg::CFG_DEV_COUNT, 32'd1);
        send_header(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'd0, {$urandom, $urandom}, 32'd1, 24);
        send_payload(2);

        // random settings, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(cfhd_pkg::CFG_MAGIC, $urandom);
        write_reg(cfhd_pkg::CFG_VERSION, $urandom_range(255));
        write_reg(cfhd_pkg::CFG_DEV_COUNT, $urandom_range(255, 1));
        write_reg(cfhd_pkg::CFG_MAX_BYTES,
                  ($urandom_range(3) == 0) ? $urandom_range(24'hFF_FFFF, 1) :
                                             $urandom_range(64, 1));
        need_restart = 1'b1;
        run_random(230);

        // drain and report
        settle_stream();
        repeat (10) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.errors == 0) begin
            $display("[camera_frame_header_deframer] OK");
        end else begin
            $display("[camera_frame_header_deframer] ERROR");
        end
        $finish;
    end

endmodule
